>>> src/msd_pkg.sv
// Shared types and constants for the Morse symbol decoder.
// Used by all other project files; no dependencies.
package msd_pkg;

    localparam int MAX_CODE_SYMBOLS_DEF = 7;
    localparam int ROM_BITS_W           = 7;
    localparam int ROM_LEN_W            = 3;
    localparam int CHAR_W               = 7;
    localparam int SYM_W                = 2;
    localparam int GAP_W                = 4;
    localparam int THR_W                = 4;
    localparam int CFG_INDEX_W          = 2;
    localparam int IN_DATA_W            = 8;
    localparam int OUT_DATA_W           = 8;

    typedef logic [CHAR_W-1:0]     char_t;
    typedef logic [ROM_BITS_W-1:0] rom_bits_t;
    typedef logic [ROM_LEN_W-1:0]  rom_len_t;
    typedef logic [SYM_W-1:0]      sym_t;

    localparam sym_t SYM_DOT  = 2'd0;
    localparam sym_t SYM_DASH = 2'd1;
    localparam sym_t SYM_GAP  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_WORD_GAP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_GAP = 2'd1;

    localparam logic [THR_W-1:0] WORD_GAP_RESET = 4'd3;
    localparam logic [THR_W-1:0] LINE_GAP_RESET = 4'd7;
    localparam logic [GAP_W-1:0] GAP_MAX        = 4'd15;

    localparam char_t CHAR_NONE    = 7'h00;
    localparam char_t CHAR_SPACE   = 7'h20;
    localparam char_t CHAR_NEWLINE = 7'h0A;

endpackage

>>> src/msd_code_rom.sv
// Morse code table: maps a closed code (length and dash bits, first symbol
// in bit 0) to its ASCII character, or to zero when the code is unknown.
// Depends on msd_pkg.
module msd_code_rom (
    input  msd_pkg::rom_bits_t code_bits,
    input  msd_pkg::rom_len_t  code_len,
    output msd_pkg::char_t     code_char
);
    import msd_pkg::*;

    always_comb begin
        case ({code_len, code_bits})
            {3'd2, 7'b0000010}: code_char = 7'h41; // A
            {3'd4, 7'b0000001}: code_char = 7'h42; // B
            {3'd4, 7'b0000101}: code_char = 7'h43; // C
            {3'd3, 7'b0000001}: code_char = 7'h44; // D
            {3'd1, 7'b0000000}: code_char = 7'h45; // E
            {3'd4, 7'b0000100}: code_char = 7'h46; // F
            {3'd3, 7'b0000011}: code_char = 7'h47; // G
            {3'd4, 7'b0000000}: code_char = 7'h48; // H
            {3'd2, 7'b0000000}: code_char = 7'h49; // I
            {3'd4, 7'b0001110}: code_char = 7'h4A; // J
            {3'd3, 7'b0000101}: code_char = 7'h4B; // K
            {3'd4, 7'b0000010}: code_char = 7'h4C; // L
            {3'd2, 7'b0000011}: code_char = 7'h4D; // M
            {3'd2, 7'b0000001}: code_char = 7'h4E; // N
            {3'd3, 7'b0000111}: code_char = 7'h4F; // O
            {3'd4, 7'b0000110}: code_char = 7'h50; // P
            {3'd4, 7'b0001011}: code_char = 7'h51; // Q
            {3'd3, 7'b0000010}: code_char = 7'h52; // R
            {3'd3, 7'b0000000}: code_char = 7'h53; // S
            {3'd1, 7'b0000001}: code_char = 7'h54; // T
            {3'd3, 7'b0000100}: code_char = 7'h55; // U
            {3'd4, 7'b0001000}: code_char = 7'h56; // V
            {3'd3, 7'b0000110}: code_char = 7'h57; // W
            {3'd4, 7'b0001001}: code_char = 7'h58; // X
            {3'd4, 7'b0001101}: code_char = 7'h59; // Y
            {3'd4, 7'b0000011}: code_char = 7'h5A; // Z
            {3'd5, 7'b0011111}: code_char = 7'h30; // 0
            {3'd5, 7'b0011110}: code_char = 7'h31; // 1
            {3'd5, 7'b0011100}: code_char = 7'h32; // 2
            {3'd5, 7'b0011000}: code_char = 7'h33; // 3
            {3'd5, 7'b0010000}: code_char = 7'h34; // 4
            {3'd5, 7'b0000000}: code_char = 7'h35; // 5
            {3'd5, 7'b0000001}: code_char = 7'h36; // 6
            {3'd5, 7'b0000011}: code_char = 7'h37; // 7
            {3'd5, 7'b0000111}: code_char = 7'h38; // 8
            {3'd5, 7'b0001111}: code_char = 7'h39; // 9
            {3'd6, 7'b0101010}: code_char = 7'h2E; // period
            {3'd6, 7'b0110011}: code_char = 7'h2C; // comma
            {3'd6, 7'b0001100}: code_char = 7'h3F; // question mark
            {3'd6, 7'b0011110}: code_char = 7'h27; // apostrophe
            {3'd6, 7'b0110101}: code_char = 7'h21; // exclamation
            {3'd5, 7'b0001001}: code_char = 7'h2F; // slash
            {3'd5, 7'b0001101}: code_char = 7'h28; // open paren
            {3'd6, 7'b0101101}: code_char = 7'h29; // close paren
            {3'd5, 7'b0000010}: code_char = 7'h26; // ampersand
            {3'd6, 7'b0000111}: code_char = 7'h3A; // colon
            {3'd6, 7'b0010101}: code_char = 7'h3B; // semicolon
            {3'd5, 7'b0010001}: code_char = 7'h3D; // equals
            {3'd5, 7'b0001010}: code_char = 7'h2B; // plus
            {3'd6, 7'b0100001}: code_char = 7'h2D; // hyphen
            {3'd6, 7'b0101100}: code_char = 7'h5F; // underscore
            {3'd6, 7'b0010010}: code_char = 7'h22; // quote
            {3'd7, 7'b1001000}: code_char = 7'h24; // dollar
            {3'd6, 7'b0010110}: code_char = 7'h40; // at sign
            default:            code_char = CHAR_NONE;
        endcase
    end

endmodule

>>> src/morse_symbol_decoder.sv
// Morse symbol decoder top level: input register, decode and gap logic,
// result register. Depends on msd_pkg and msd_code_rom.
// A symbol transfers into the input register, is decoded combinationally and, if it
// yields a character, is captured in the result register, from which it transfers.
// Throughput: one symbol per cycle while the result channel is not stalled; the input
// register and the result register advance together, so the rate is set by the single decode stage.
// Reset (aresetn low, synchronous): pending code and gap count cleared,
// both channels empty, word gap 3 and line gap 7.
module morse_symbol_decoder #(
    parameter int MAX_CODE_SYMBOLS = msd_pkg::MAX_CODE_SYMBOLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [msd_pkg::IN_DATA_W-1:0]      s_tdata,   // [1:0] symbol, rest zero
    input  logic                               s_tlast,   // message_end
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [msd_pkg::OUT_DATA_W-1:0]     m_tdata,   // [6:0] out_char, [7] zero
    output logic                               m_tlast,   // from_end
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [msd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [msd_pkg::THR_W-1:0]          cfg_data
);
    import msd_pkg::*;

    localparam int CODE_W = MAX_CODE_SYMBOLS;
    localparam int LEN_W  = $clog2(MAX_CODE_SYMBOLS + 1);

    logic [THR_W-1:0]  word_gap_reg, line_gap_reg;
    logic [CODE_W-1:0] code_bits_reg, code_bits_next;
    logic [LEN_W-1:0]  code_len_reg, code_len_next;
    logic              code_ovf_reg, code_ovf_next;
    logic [GAP_W-1:0]  gap_count_reg, gap_count_next;

    logic              in_valid_reg, in_valid_next;
    sym_t              in_sym_reg;
    logic              in_end_reg;

    logic              out_valid_reg, out_valid_next;
    char_t             out_char_reg;
    logic              out_end_reg;

    logic              s_accept, advance, has_result;
    logic              is_mark, is_gap, close_code;
    logic [CODE_W-1:0] bits1;
    logic [LEN_W-1:0]  len1;
    logic              ovf1;
    logic [GAP_W-1:0]  gap_inc;
    char_t             rom_char, code_char, gap_char, result_char;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready || !has_result);
    assign s_tready  = !in_valid_reg || advance;

    assign is_mark = (in_sym_reg == SYM_DOT) || (in_sym_reg == SYM_DASH);
    assign is_gap  = (in_sym_reg == SYM_GAP);

    always_comb begin
        bits1 = code_bits_reg;
        len1  = code_len_reg;
        ovf1  = code_ovf_reg;
        if (is_mark) begin
            if (code_len_reg < LEN_W'(MAX_CODE_SYMBOLS)) begin
                bits1 = code_bits_reg | (CODE_W'(in_sym_reg[0]) << code_len_reg);
                len1  = code_len_reg + LEN_W'(1);
            end else begin
                ovf1 = 1'b1;
            end
        end
    end

    assign close_code = (is_gap || in_end_reg) && ((len1 != '0) || ovf1);

    msd_code_rom u_rom (
        .code_bits (ROM_BITS_W'(bits1)),
        .code_len  (ROM_LEN_W'(len1)),
        .code_char (rom_char)
    );

    assign code_char = (close_code && !ovf1) ? rom_char : CHAR_NONE;
    assign gap_inc   = (gap_count_reg == GAP_MAX) ? GAP_MAX : gap_count_reg + GAP_W'(1);

    always_comb begin
        gap_char       = CHAR_NONE;
        gap_count_next = gap_count_reg;
        if (is_mark) begin
            gap_count_next = '0;
        end else if (is_gap) begin
            gap_count_next = gap_inc;
            if (gap_inc >= line_gap_reg) begin
                gap_char       = CHAR_NEWLINE;
                gap_count_next = '0;
            end else if (gap_inc == word_gap_reg) begin
                gap_char = CHAR_SPACE;
            end
        end
        if (in_end_reg) begin
            gap_count_next = '0;
        end
    end

    always_comb begin
        if (close_code || in_end_reg) begin
            code_bits_next = '0;
            code_len_next  = '0;
            code_ovf_next  = 1'b0;
        end else begin
            code_bits_next = bits1;
            code_len_next  = len1;
            code_ovf_next  = ovf1;
        end
    end

    assign result_char = (code_char != CHAR_NONE) ? code_char : gap_char;
    assign has_result  = (result_char != CHAR_NONE);

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = (advance && has_result) || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_gap_reg  <= WORD_GAP_RESET;
            line_gap_reg  <= LINE_GAP_RESET;
            code_bits_reg <= '0;
            code_len_reg  <= '0;
            code_ovf_reg  <= 1'b0;
            gap_count_reg <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WORD_GAP: word_gap_reg <= cfg_data;
                    REG_LINE_GAP: line_gap_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (advance) begin
                code_bits_reg <= code_bits_next;
                code_len_reg  <= code_len_next;
                code_ovf_reg  <= code_ovf_next;
                gap_count_reg <= gap_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sym_reg <= s_tdata[SYM_W-1:0];
            in_end_reg <= s_tlast;
        end
        if (advance && has_result) begin
            out_char_reg <= result_char;
            out_end_reg  <= in_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_char_reg);
    assign m_tlast  = out_end_reg;

endmodule

>>> verif/msd_checker.sv
// Decoded-text checker for morse_symbol_decoder: watches the symbol, result and
// register channels, predicts each character and compares it on transfer.
// Depends on msd_pkg.
module msd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [msd_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [msd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [msd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [msd_pkg::THR_W-1:0]       cfg_data,
    output int                              mismatches,
    output int                              pending
);
    import msd_pkg::*;

    localparam int MAX_SYMS  = MAX_CODE_SYMBOLS_DEF;
    localparam int ROM_DEPTH = 54;

    typedef struct packed {
        char_t ch;
        logic  fin;
    } text_char_t;

    string morse_pat [ROM_DEPTH] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.",
        ".-.-.-", "--..--", "..--..", ".----.", "-.-.--", "-..-.", "-.--.",
        "-.--.-", ".-...", "---...", "-.-.-.", "-...-", ".-.-.", "-....-",
        "..--.-", ".-..-.", "...-..-", ".--.-."
    };
    string morse_chr = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"$@";

    text_char_t       expected_chars [$];
    rom_bits_t        code_bits;
    int               code_len;
    logic             code_ovf;
    logic [GAP_W-1:0] gap_cnt;
    logic [THR_W-1:0] word_thr;
    logic [THR_W-1:0] line_thr;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic char_t lookup_char(rom_bits_t bits, int len);
        string p;
        bit    hit;
        for (int r = 0; r < ROM_DEPTH; r++) begin
            p = morse_pat[r];
            if (p.len() == len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++) begin
                    if ((p[k] == "-") != bits[k]) hit = 1'b0;
                end
                if (hit) return char_t'(morse_chr[r]);
            end
        end
        return CHAR_NONE;
    endfunction

    task automatic clear_code();
        code_bits = '0;
        code_len  = 0;
        code_ovf  = 1'b0;
    endtask

    task automatic decode_symbol(sym_t sym, logic fin);
        char_t ch;
        char_t gap_ch;
        ch = CHAR_NONE;
        if (sym == SYM_DOT || sym == SYM_DASH) begin
            gap_cnt = '0;
            if (code_len < MAX_SYMS) begin
                code_bits[code_len] = (sym == SYM_DASH);
                code_len++;
            end else begin
                code_ovf = 1'b1;
            end
        end
        if ((sym == SYM_GAP || fin) && (code_len > 0 || code_ovf)) begin
            if (!code_ovf) ch = lookup_char(code_bits, code_len);
            clear_code();
        end
        if (sym == SYM_GAP) begin
            gap_ch = CHAR_NONE;
            if (gap_cnt != GAP_MAX) gap_cnt++;
            if (gap_cnt >= line_thr) begin
                gap_ch  = CHAR_NEWLINE;
                gap_cnt = '0;
            end else if (gap_cnt == word_thr) begin
                gap_ch = CHAR_SPACE;
            end
            if (ch == CHAR_NONE) ch = gap_ch;
        end
        if (fin) begin
            gap_cnt = '0;
            clear_code();
        end
        if (ch != CHAR_NONE) expected_chars.push_back('{ch: ch, fin: fin});
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch, got 'h%0h, expected 'h%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_char();
        text_char_t want;
        if (expected_chars.size() == 0) begin
            report_mismatch("unexpected result", int'(m_tdata), 0);
        end else begin
            want = expected_chars.pop_front();
            if (m_tdata[CHAR_W-1:0] !== want.ch)
                report_mismatch("out_char", int'(m_tdata[CHAR_W-1:0]), int'(want.ch));
            if (m_tlast !== want.fin)
                report_mismatch("from_end", int'(m_tlast), int'(want.fin));
            if (m_tdata[OUT_DATA_W-1:CHAR_W] !== '0)
                report_mismatch("tdata pad", int'(m_tdata[OUT_DATA_W-1:CHAR_W]), 0);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            word_thr = WORD_GAP_RESET;
            line_thr = LINE_GAP_RESET;
            gap_cnt  = '0;
            clear_code();
            expected_chars.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WORD_GAP) word_thr = cfg_data;
                else if (cfg_index == REG_LINE_GAP) line_thr = cfg_data;
            end
            if (m_tvalid && m_tready) check_char();
            if (s_tvalid && s_tready) decode_symbol(sym_t'(s_tdata[SYM_W-1:0]), s_tlast);
        end
        pending <= expected_chars.size();
    end

endmodule

>>> verif/testbench.sv
// Testbench top for morse_symbol_decoder: clock, reset, symbol and register stimulus,
// random back-pressure and the verdict. Needs msd_pkg, msd_checker and the decoder.
module testbench;
    import msd_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 95;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [THR_W-1:0]       cfg_data;

    int   mismatches;
    int   pending;
    int   sent;
    int   quiet_cycles;
    int   sink_hold;
    logic sink_stalls;
    bit   src_stalls;

    morse_symbol_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    msd_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(15, 50);
        return $urandom_range(1, 3);
    endfunction

    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            sink_hold <= idle_len() - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_symbol(sym_t sym, logic fin);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(sym);
        s_tlast  <= fin;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        sent++;
        if (src_stalls && $urandom_range(0, 3) == 0) begin
            gap = idle_len();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold off until every expected character has come and the pipe is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [THR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
    endtask

    task automatic send_code(string pat, logic fin_last);
        for (int k = 0; k < pat.len(); k++)
            send_symbol((pat[k] == "-") ? SYM_DASH : SYM_DOT, fin_last && k == pat.len() - 1);
    endtask

    task automatic random_words(int items);
        int stop;
        int len;
        int gaps;
        bit end_msg;
        bit end_on_sym;
        stop = sent + items;
        while (sent < stop) begin
            if ($urandom_range(0, 9) == 0) begin
                send_symbol(sym_t'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
            end else begin
                len        = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 9)
                                                         : $urandom_range(1, 4);
                gaps       = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 17)
                                                         : $urandom_range(1, 3);
                end_msg    = $urandom_range(0, 7) == 0;
                end_on_sym = end_msg && $urandom_range(0, 1) == 0;
                if (end_on_sym) gaps = 0;
                for (int i = 0; i < len; i++)
                    send_symbol(sym_t'($urandom_range(0, 1)), end_on_sym && i == len - 1);
                for (int i = 0; i < gaps; i++)
                    send_symbol(SYM_GAP, end_msg && i == gaps - 1);
            end
        end
    endtask

    task automatic run_phase(logic [THR_W-1:0] word_units, logic [THR_W-1:0] line_units);
        drain_results();
        write_reg(REG_WORD_GAP, word_units);
        write_reg(REG_LINE_GAP, line_units);
        cfg_valid   <= 1'b0;
        src_stalls   = $urandom_range(0, 3) != 0;
        sink_stalls <= $urandom_range(0, 3) != 0;
        random_words(PHASE_ITEMS);
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_WORD_GAP;
        cfg_data     = '0;
        sent         = 0;
        quiet_cycles = 0;
        sink_hold    = 0;
        sink_stalls  = 1'b1;
        src_stalls   = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset thresholds: letter, letter on message end, overflow, unknown code,
        // symbol code 3 closing on message end, then a space and a newline
        send_code(".-", 1'b0);
        send_symbol(SYM_GAP, 1'b0);
        send_code("-", 1'b1);
        send_code("--------", 1'b0);
        send_symbol(SYM_GAP, 1'b0);
        send_code("..--", 1'b0);
        send_symbol(SYM_GAP, 1'b0);
        send_code("-", 1'b0);
        send_symbol(sym_t'(2'd3), 1'b1);
        repeat (7) send_symbol(SYM_GAP, 1'b0);

        run_phase(4'd0, 4'd0);
        run_phase(4'd15, 4'd15);
        run_phase(4'd1, 4'd1);
        run_phase(4'd1, 4'd15);
        run_phase(4'd15, 4'd1);
        run_phase(4'd3, 4'd7);
        run_phase(THR_W'($urandom_range(1, 15)), THR_W'($urandom_range(1, 15)));

        drain_results();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
src/msd_pkg.sv
src/msd_code_rom.sv
src/morse_symbol_decoder.sv
verif/msd_checker.sv
verif/testbench.sv
